### hw/rtl/bdr_pkg.sv
package bdr_pkg;

	// Field widths fixed by the record format.
	localparam int CFG_W       = 11;
	localparam int COL_W       = 10;
	localparam int MAX_WIDTH   = 1024;
	localparam int WIDTH_RESET = 640;

	// Largest usable row width, rounded down to even.
	localparam int MAX_EVEN    = MAX_WIDTH - (MAX_WIDTH % 2);

	// One decoded pixel with its position in the record.
	typedef struct packed {
		logic [7:0]       value;
		logic [1:0]       row;
		logic [COL_W-1:0] column;
		logic             done;
	} pix_t;

	// Requests from the decoder to the bit queue.
	typedef struct packed {
		logic load;
		logic clear;
		logic take;
	} bq_ctl_t;

	// Decoder status seen by the sequencer.
	typedef struct packed {
		logic work;
		logic emit;
	} core_stat_t;

endpackage

### hw/rtl/bdr_bitq.sv
module bdr_bitq (
	input  logic            clk,
	input  logic            arst_n,
	input  bdr_pkg::bq_ctl_t ctl,
	input  logic [7:0]      data_byte,
	output logic            next_bit,
	output logic            held_nz
);
	import bdr_pkg::*;

	logic [15:0] buf_q;
	logic [4:0]  held_q;
	logic [4:0]  held_sum;

	// The oldest unused bit sits just below the fill count.
	assign next_bit = buf_q[4'(held_q - 5'd1)];
	assign held_nz  = (held_q != 5'd0);
	assign held_sum = held_q + 5'd8;

	// Clearing wins over consuming; loading never meets a take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
		end else if (ctl.clear) begin
			buf_q  <= '0;
			held_q <= '0;
		end else if (ctl.load) begin
			buf_q  <= {buf_q[7:0], data_byte};
			held_q <= (held_sum > 5'd16) ? 5'd16 : held_sum;
		end else if (ctl.take) begin
			held_q <= held_q - 5'd1;
		end
	end

endmodule

### hw/rtl/bdr_core.sv
module bdr_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_acc,
	input  logic [7:0]                  data_byte,
	input  logic                        start,
	input  logic [bdr_pkg::CFG_W-1:0]   image_width,
	input  logic                        step_en,
	input  logic                        next_bit,
	input  logic                        held_nz,
	output bdr_pkg::core_stat_t         stat,
	output bdr_pkg::pix_t               res,
	output bdr_pkg::bq_ctl_t            bq
);
	import bdr_pkg::*;

	localparam logic [1:0] STEP_LIT  = 2'd0;
	localparam logic [1:0] STEP_FLAG = 2'd1;
	localparam logic [1:0] STEP_CODE = 2'd2;
	localparam logic [1:0] STEP_RAW  = 2'd3;

	localparam logic [2:0] PHASE_LAST = 3'd5;
	localparam logic [2:0] PHASE_DONE = 3'd6;
	localparam logic [1:0] SEG_BLUE   = 2'd0;
	localparam logic [1:0] SEG_RED    = 2'd1;
	localparam logic [1:0] SEG_GREEN  = 2'd2;
	localparam logic [3:0] MAX_EMITS  = 4'd8;

	logic [1:0]       step_q;
	logic [2:0]       phase_q;
	logic [COL_W-1:0] col_q;
	logic [7:0]       pred_q;
	logic [7:0]       acc_q;
	logic [2:0]       bitcnt_q;
	logic             lit_q;
	logic [7:0]       litbyte_q;
	logic [3:0]       cnt_q;

	logic [CFG_W-1:0] w_raw;
	logic [CFG_W-1:0] eff_w;
	logic [CFG_W-1:0] seg_len;
	logic [CFG_W-1:0] m1;
	logic [1:0]       seg;
	logic             pair;
	logic             seg_end;
	logic             lit_next;
	logic             live;
	logic [4:0]       code;
	logic             emit;
	logic [7:0]       val;

	// Effective row width: even, at least two, at most the column range.
	always_comb begin
		w_raw = {image_width[CFG_W-1:1], 1'b0};
		eff_w = w_raw;
		if (w_raw > CFG_W'(MAX_EVEN)) begin
			eff_w = CFG_W'(MAX_EVEN);
		end else if (w_raw < CFG_W'(2)) begin
			eff_w = CFG_W'(2);
		end
	end

	// Segment kind and row pair of the current phase.
	always_comb begin
		unique case (phase_q)
			3'd0:    begin seg = SEG_BLUE;  pair = 1'b0; end
			3'd1:    begin seg = SEG_RED;   pair = 1'b0; end
			3'd2:    begin seg = SEG_GREEN; pair = 1'b0; end
			3'd3:    begin seg = SEG_BLUE;  pair = 1'b1; end
			3'd4:    begin seg = SEG_RED;   pair = 1'b1; end
			3'd5:    begin seg = SEG_GREEN; pair = 1'b1; end
			default: begin seg = SEG_BLUE;  pair = 1'b0; end
		endcase
	end

	// Segment length and position bookkeeping.
	always_comb begin
		seg_len  = (seg == SEG_GREEN) ? eff_w : {1'b0, eff_w[CFG_W-1:1]};
		m1       = {1'b0, col_q} + CFG_W'(1);
		seg_end  = (m1 >= seg_len);
		lit_next = (seg == SEG_GREEN) && (col_q == '0);
		live     = (phase_q < PHASE_DONE);
	end

	// One bit of the current code per step; a value completes on its last bit.
	always_comb begin
		code = {acc_q[3:0], next_bit};
		emit = 1'b0;
		val  = pred_q;
		if (lit_q) begin
			emit = 1'b1;
			val  = litbyte_q;
		end else begin
			unique case (step_q)
				STEP_FLAG: begin
					emit = next_bit;
					val  = pred_q;
				end
				STEP_CODE: begin
					emit = (bitcnt_q == 3'd4) && (code != 5'd0);
					val  = code[4] ? (pred_q - {4'd0, code[3:0]})
					               : (pred_q + {4'd0, code[3:0]});
				end
				STEP_RAW: begin
					emit = (bitcnt_q == 3'd7);
					val  = {acc_q[6:0], next_bit};
				end
				STEP_LIT: begin
					emit = 1'b0;
					val  = pred_q;
				end
			endcase
		end
	end

	// Status, pixel tags and bit queue requests.
	always_comb begin
		stat.work = live && (lit_q || ((step_q != STEP_LIT) && held_nz && (cnt_q < MAX_EMITS)));
		stat.emit = emit;

		res.value = val;
		res.done  = seg_end && (phase_q == PHASE_LAST);
		unique case (seg)
			SEG_BLUE: begin
				res.row    = {pair, 1'b0};
				res.column = {col_q[COL_W-2:0], 1'b1};
			end
			SEG_RED: begin
				res.row    = {pair, 1'b1};
				res.column = {col_q[COL_W-2:0], 1'b0};
			end
			default: begin
				res.row    = {pair, col_q[0]};
				res.column = col_q;
			end
		endcase

		bq.take  = step_en && !lit_q;
		bq.load  = in_acc && !start && live && (step_q != STEP_LIT);
		bq.clear = (in_acc && (start || (live && (step_q == STEP_LIT))))
		        || (step_en && emit && seg_end);
	end

	// Decoder state: byte intake, code stepping and segment advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_LIT;
			phase_q  <= '0;
			col_q    <= '0;
			pred_q   <= '0;
			bitcnt_q <= '0;
			lit_q    <= 1'b0;
			cnt_q    <= '0;
		end else if (in_acc) begin
			cnt_q <= '0;
			if (start) begin
				step_q   <= STEP_LIT;
				phase_q  <= '0;
				col_q    <= '0;
				pred_q   <= '0;
				bitcnt_q <= '0;
				lit_q    <= 1'b1;
			end else if (live && (step_q == STEP_LIT)) begin
				lit_q <= 1'b1;
			end
		end else if (step_en) begin
			if (lit_q) begin
				lit_q <= 1'b0;
			end else begin
				unique case (step_q)
					STEP_FLAG: begin
						if (!next_bit) begin
							step_q   <= STEP_CODE;
							bitcnt_q <= '0;
						end
					end
					STEP_CODE: begin
						bitcnt_q <= bitcnt_q + 3'd1;
						if ((bitcnt_q == 3'd4) && (code == 5'd0)) begin
							step_q   <= STEP_RAW;
							bitcnt_q <= '0;
						end
					end
					STEP_RAW: begin
						bitcnt_q <= bitcnt_q + 3'd1;
					end
					STEP_LIT: begin
						bitcnt_q <= bitcnt_q;
					end
				endcase
			end
			if (emit) begin
				cnt_q  <= cnt_q + 4'd1;
				pred_q <= val;
				if (seg_end) begin
					phase_q <= phase_q + 3'd1;
					col_q   <= '0;
					step_q  <= STEP_LIT;
				end else begin
					col_q  <= col_q + COL_W'(1);
					step_q <= lit_next ? STEP_LIT : STEP_FLAG;
				end
			end
		end
	end

	// Code bits shift in one per step; the literal byte waits whole.
	always_ff @(posedge clk) begin
		if (step_en && !lit_q) begin
			acc_q <= {acc_q[6:0], next_bit};
		end
		if (in_acc) begin
			litbyte_q <= data_byte;
		end
	end

endmodule

### hw/rtl/bayer_dpcm_record_decoder.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_ready  | byte_in, record_start
// out     | output    | out_valid, out_ready| pixel_value, pixel_row, pixel_column,
//         |           |                     | run_last, record_done
// cfg     | input     | cfg_valid, cfg_ready| image_width
//
// A byte is taken while the decoder is idle, then decoded one bit per cycle; a stalled
// output pauses the bit loop. A literal byte is taken whole, and a final step releases
// the byte's last pixel. A new byte is not accepted until the current one is finished.
// Reset sets image_width to 640 and the decoder to the blue segment of the first pair.
// A pixel is held in a pending register so that run_last can be marked on the byte's final pixel.
module bayer_dpcm_record_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      byte_in,
	input  logic                            record_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      pixel_value,
	output logic [1:0]                      pixel_row,
	output logic [bdr_pkg::COL_W-1:0]       pixel_column,
	output logic                            run_last,
	output logic                            record_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdr_pkg::CFG_W-1:0]       image_width
);
	import bdr_pkg::*;

	logic             busy_q;
	logic             pend_v_q;
	pix_t             pend_q;
	logic             out_v_q;
	pix_t             out_q;
	logic             last_q;
	logic [CFG_W-1:0] width_q;

	logic       in_acc;
	logic       out_free;
	logic       step_en;
	logic       fin;
	logic       push;
	core_stat_t stat;
	pix_t       res;
	bq_ctl_t    bq;
	logic       next_bit;
	logic       held_nz;

	bdr_bitq u_bitq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (bq),
		.data_byte (byte_in),
		.next_bit  (next_bit),
		.held_nz   (held_nz)
	);

	bdr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.data_byte   (byte_in),
		.start       (record_start),
		.image_width (width_q),
		.step_en     (step_en),
		.next_bit    (next_bit),
		.held_nz     (held_nz),
		.stat        (stat),
		.res         (res),
		.bq          (bq)
	);

	// Handshakes and step control.
	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_v_q || out_ready;
	assign step_en   = busy_q && stat.work && (!stat.emit || !pend_v_q || out_free);
	assign fin       = busy_q && !stat.work && (!pend_v_q || out_free);
	assign push      = pend_v_q && ((step_en && stat.emit) || fin);

	// Output port drive.
	assign out_valid    = out_v_q;
	assign pixel_value  = out_q.value;
	assign pixel_row    = out_q.row;
	assign pixel_column = out_q.column;
	assign record_done  = out_q.done;
	assign run_last     = last_q;

	// Control registers and the width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			width_q  <= CFG_W'(WIDTH_RESET);
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q <= image_width;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (step_en && stat.emit) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Pending pixel and output register payload.
	always_ff @(posedge clk) begin
		if (step_en && stat.emit) begin
			pend_q <= res;
		end
		if (push) begin
			out_q  <= pend_q;
			last_q <= fin;
		end
	end

	// The held pixel never outlives the byte that made it.
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !pend_v_q)
		else $error("pending pixel held while idle");

	// The final pixel of a record always closes its byte's run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_done |-> run_last)
		else $error("record end without run end");

	// Finishing a byte with a held pixel presents it marked as last.
	a_fin_push: assert property (@(posedge clk) disable iff (!arst_n)
		fin && pend_v_q |=> out_valid && run_last)
		else $error("last pixel of a byte not presented");

	// A decode step never runs while a new item is taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !step_en && !fin)
		else $error("item taken during decode");

endmodule
